FILE: src/tksk_pkg.sv
`default_nettype none
package tksk_pkg;

  // Buffer geometry
  localparam int SLOTS        = 20;
  localparam int USER_ID_BITS = 20;

  // Fixed field widths of the stream payloads
  localparam int SCORE_W   = 16;
  localparam int USER_W    = 20;
  localparam int SLOT_W    = 5;
  localparam int IN_DATA_W = 48;   // score + user_id + slot, padded to bytes
  localparam int OUT_DATA_W = 64;  // six result fields, padded to bytes

  // Bit positions in s_axis_tdata
  localparam int IN_SCORE_LSB = 0;
  localparam int IN_USER_LSB  = IN_SCORE_LSB + SCORE_W;
  localparam int IN_SLOT_LSB  = IN_USER_LSB + USER_W;

  // Score that marks an empty slot (minus one in Q1.15)
  localparam logic signed [SCORE_W-1:0] SCORE_MINUS_ONE = {1'b1, {(SCORE_W-1){1'b0}}};

  // Operation codes carried on s_axis_tuser
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  // Output register occupancy
  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } out_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_insert;
    logic take_read;
  } tksk_cmd_t;

  // One result item
  typedef struct packed {
    logic                      read_valid;
    logic signed [SCORE_W-1:0] read_score;
    logic [USER_W-1:0]         read_user;
    logic                      dropped_valid;
    logic [USER_W-1:0]         dropped_user;
    logic                      accepted;
  } tksk_result_t;

endpackage
`default_nettype wire

FILE: src/tksk_ctrl.sv
`default_nettype none
module tksk_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_valid_i,
  input  wire logic             s_op_i,
  output logic                  s_ready_o,
  output logic                  m_valid_o,
  input  wire logic             m_ready_i,
  output tksk_pkg::tksk_cmd_t   cmd_o
);
  import tksk_pkg::*;

  out_state_e state_q, state_d;
  logic       take;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands: a new item may enter when the result slot
  // is empty or is being drained in the same cycle
  always_comb begin
    s_ready_o = (state_q == ST_EMPTY) || m_ready_i;
    m_valid_o = (state_q == ST_FULL);
    take      = s_valid_i && s_ready_o;
    cmd_o.take_insert = take && (op_e'(s_op_i) == OP_INSERT);
    cmd_o.take_read   = take && (op_e'(s_op_i) == OP_READ);
    state_d = state_q;
    unique case (state_q)
      ST_EMPTY: begin
        if (take) state_d = ST_FULL;
      end
      ST_FULL: begin
        if (m_ready_i && !take) state_d = ST_EMPTY;
      end
      default: state_d = ST_EMPTY;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/tksk_datapath.sv
`default_nettype none
module tksk_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  tksk_pkg::tksk_cmd_t                      cmd_i,
  input  wire logic signed [tksk_pkg::SCORE_W-1:0] score_i,
  input  wire logic [tksk_pkg::USER_W-1:0]         user_id_i,
  input  wire logic [tksk_pkg::SLOT_W-1:0]         slot_i,
  output tksk_pkg::tksk_result_t                   result_o
);
  import tksk_pkg::*;

  localparam int CMP_W = $clog2(SLOTS + 1) > SLOT_W ? $clog2(SLOTS + 1) : SLOT_W;

  logic signed [SCORE_W-1:0]  score_q [SLOTS];
  logic [USER_ID_BITS-1:0]    user_q  [SLOTS];
  logic [SLOTS-1:0]           valid_q;
  logic [SLOTS-1:0]           gt;
  logic [USER_ID_BITS-1:0]    new_user;
  tksk_result_t               res_d, res_q;
  logic [USER_ID_BITS-1:0]    rd_user;
  logic signed [SCORE_W-1:0]  rd_score;
  logic                       rd_valid;

  assign new_user = USER_ID_BITS'(user_id_i);

  // Per-cell compare: newcomer strictly above this cell's score
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      gt[i] = score_i > score_q[i];
    end
  end

  // Sorted cells: a cell takes its upper neighbor when the newcomer passes
  // that neighbor too, else takes the newcomer when it passes this cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        score_q[i] <= SCORE_MINUS_ONE;
        user_q[i]  <= '0;
      end
      valid_q <= '0;
    end else if (cmd_i.take_insert && gt[0]) begin
      for (int i = 0; i < SLOTS - 1; i++) begin
        if (gt[i+1]) begin
          score_q[i] <= score_q[i+1];
          user_q[i]  <= user_q[i+1];
          valid_q[i] <= valid_q[i+1];
        end else if (gt[i]) begin
          score_q[i] <= score_i;
          user_q[i]  <= new_user;
          valid_q[i] <= 1'b1;
        end
      end
      if (gt[SLOTS-1]) begin
        score_q[SLOTS-1] <= score_i;
        user_q[SLOTS-1]  <= new_user;
        valid_q[SLOTS-1] <= 1'b1;
      end
    end
  end

  // Slot read select; out-of-range slots read as zero
  always_comb begin
    rd_user  = '0;
    rd_score = '0;
    rd_valid = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (CMP_W'(slot_i) == CMP_W'(i)) begin
        rd_user  = rd_user | user_q[i];
        rd_score = rd_score | score_q[i];
        rd_valid = rd_valid | valid_q[i];
      end
    end
  end

  // Result forming
  always_comb begin
    res_d = '0;
    if (cmd_i.take_read) begin
      res_d.read_user  = USER_W'(rd_user);
      res_d.read_score = rd_score;
      res_d.read_valid = rd_valid;
    end else if (gt[0]) begin
      res_d.accepted      = 1'b1;
      res_d.dropped_user  = USER_W'(user_q[0]);
      res_d.dropped_valid = valid_q[0];
    end else begin
      res_d.dropped_user  = USER_W'(new_user);
      res_d.dropped_valid = 1'b1;
    end
  end

  // Output register, loaded on each accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_insert || cmd_i.take_read) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule
`default_nettype wire

FILE: src/top_k_score_keeper_top.sv
// Top-k score keeper: holds the SLOTS highest-scoring candidates seen so far
// in a row of sorted cells, slot 0 lowest. An insert (tuser = 0) is kept only
// if its score is strictly above slot 0; then slot 0 is evicted, lower cells
// shift down and the newcomer lands just below the first cell whose score is
// equal or higher. A read (tuser = 1) returns one slot. All cells compare
// against the newcomer in parallel and update in the same edge, with the
// result captured in an output register, so a new item is taken every cycle
// as long as the result side keeps draining. Slots reset to score minus one,
// user zero, invalid; no clearing pass is needed.
`default_nettype none
module top_k_score_keeper_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // score[15:0], user_id[35:16], slot[40:36]
  input  wire logic        s_axis_tuser,  // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata   // accepted[0], dropped_user[20:1],
                                          // dropped_valid[21], read_user[41:22],
                                          // read_score[57:42], read_valid[58]
);
  import tksk_pkg::*;

  tksk_cmd_t    cmd;
  tksk_result_t result;

  // Handshake control
  tksk_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_op_i    (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  // Sorted cells and result register
  tksk_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .score_i   (s_axis_tdata[IN_SCORE_LSB +: SCORE_W]),
    .user_id_i (s_axis_tdata[IN_USER_LSB +: USER_W]),
    .slot_i    (s_axis_tdata[IN_SLOT_LSB +: SLOT_W]),
    .result_o  (result)
  );

  assign m_axis_tdata = OUT_DATA_W'(result);

endmodule
`default_nettype wire
